### hdl/oks_pkg.sv
// Package for the ordered key set: sizes, action and status codes, and the
// command that the control logic hands to every list cell.
// No dependencies.
package oks_pkg;

  localparam int CODE_SPACE  = 256;
  localparam int MAX_HELD    = 16;
  localparam int CODE_W      = 8;
  localparam int POS_W       = 4;
  localparam int OUT_COUNT_W = 5;
  localparam int CNT_W       = $clog2(MAX_HELD + 1);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_NO_CHANGE    = 2'd1,
    ST_FULL         = 2'd2,
    ST_BAD_POSITION = 2'd3
  } status_t;

  // Broadcast to all cells in the cycle a transaction is accepted.
  typedef struct packed {
    logic              add_en;
    logic              rem_en;
    logic              clr_en;
    logic [CODE_W-1:0] key;
  } cell_cmd_t;

endpackage

### hdl/ordered_key_set.sv
// Top level of the ordered key set: command decode, the row of list cells,
// read selection and the registered result port.
// Depends on oks_pkg and oks_cell.
//
// Usage. A transaction is accepted at a rising clock edge where start is
// high and busy is low. in_action selects add, remove, clear or read;
// in_key_code is the code to add or remove and in_position the list
// position to read, with the oldest held code at position 0.
// Every transaction produces exactly one result, shown on out_status,
// out_held_count and out_code_read for one cycle while out_valid is high.
// The result appears in the cycle right after the accepting edge. The
// cell row completes each transaction at its accepting edge, so busy
// stays low and a new transaction may be accepted at every edge, giving a
// throughput of one transaction per cycle.
// The held codes live in a row of cells. All cells compare their code with
// the key at once; the OR of those matches is the membership answer, so no
// separate bitmap is stored. On a remove, the matching cell and all cells
// above it take their upper neighbor's contents in the same cycle, which
// closes the gap and keeps arrival order. An add writes the first empty
// cell. Adding a code that is not held to a full list reports full and changes nothing.
// Synchronous reset empties the set and drops any pending result. The
// receiver cannot stall, so results never wait.
module ordered_key_set (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_action,
  input  logic [oks_pkg::CODE_W-1:0]      in_key_code,
  input  logic [oks_pkg::POS_W-1:0]       in_position,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [oks_pkg::OUT_COUNT_W-1:0] out_held_count,
  output logic [oks_pkg::CODE_W-1:0]      out_code_read
);

  localparam int N = oks_pkg::MAX_HELD;

  oks_pkg::action_t   action;
  oks_pkg::cell_cmd_t cmd;
  logic               accept;

  // Neighbor links of the cell row.
  logic [N-1:0]                     cell_hit;
  logic [N-1:0]                     cell_valid;
  logic [N:0]                       shift_chain;
  logic [oks_pkg::CODE_W-1:0]       cell_code [N];

  logic                             any_hit;
  logic                             key_in_space;
  logic                             pos_ok;
  logic [oks_pkg::CODE_W-1:0]       read_code;

  logic [oks_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic                             out_valid_r;
  oks_pkg::status_t                 status_nxt, out_status_r;
  logic [oks_pkg::OUT_COUNT_W-1:0]  out_held_count_r;
  logic [oks_pkg::CODE_W-1:0]       code_read_nxt, out_code_read_r;

  // Every transaction completes at its accepting edge, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign action = oks_pkg::action_t'(in_action);

  assign key_in_space = int'(in_key_code) < oks_pkg::CODE_SPACE;

  // Membership is the OR of all cell matches.
  always_comb begin
    any_hit = 1'b0;
    for (int i = 0; i < N; i++) begin
      any_hit = any_hit | cell_hit[i];
    end
  end

  // Read selection over the cells.
  assign pos_ok = (int'(in_position) < int'(count_r)) && (int'(in_position) < N);

  always_comb begin
    read_code = '0;
    for (int i = 0; i < N; i++) begin
      if (int'(in_position) == i) begin
        read_code = cell_code[i];
      end
    end
  end

  // Command decode: what the cells do and what the result says.
  always_comb begin
    cmd           = '0;
    cmd.key       = in_key_code;
    count_nxt     = count_r;
    status_nxt    = oks_pkg::ST_DONE;
    code_read_nxt = '0;
    unique case (action)
      oks_pkg::ACT_ADD: begin
        if (!key_in_space || any_hit) begin
          status_nxt = oks_pkg::ST_NO_CHANGE;
        end else if (int'(count_r) >= N) begin
          status_nxt = oks_pkg::ST_FULL;
        end else begin
          cmd.add_en = accept;
          count_nxt  = count_r + 1'b1;
        end
      end
      oks_pkg::ACT_REMOVE: begin
        // Cells only ever hold codes inside the code space, so an out of
        // range key never matches.
        if (!any_hit) begin
          status_nxt = oks_pkg::ST_NO_CHANGE;
        end else begin
          cmd.rem_en = accept;
          count_nxt  = count_r - 1'b1;
        end
      end
      oks_pkg::ACT_CLEAR: begin
        cmd.clr_en = accept;
        count_nxt  = '0;
      end
      oks_pkg::ACT_READ: begin
        if (pos_ok) begin
          code_read_nxt = read_code;
        end else begin
          status_nxt = oks_pkg::ST_BAD_POSITION;
        end
      end
      default: begin
        status_nxt = oks_pkg::ST_DONE;
      end
    endcase
  end

  // The cell row. Cell 0 always sees a valid lower neighbor; the top cell
  // shifts in an empty slot on a remove.
  assign shift_chain[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic                       prev_valid;
    logic [oks_pkg::CODE_W-1:0] nxt_code;
    logic                       nxt_valid;

    if (g == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = cell_valid[g-1];
    end

    if (g == N - 1) begin : g_last
      assign nxt_code  = '0;
      assign nxt_valid = 1'b0;
    end else begin : g_link
      assign nxt_code  = cell_code[g+1];
      assign nxt_valid = cell_valid[g+1];
    end

    oks_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_valid (prev_valid),
      .hit_below  (shift_chain[g]),
      .nxt_code   (nxt_code),
      .nxt_valid  (nxt_valid),
      .hit        (cell_hit[g]),
      .shift_out  (shift_chain[g+1]),
      .code       (cell_code[g]),
      .valid      (cell_valid[g])
    );
  end

  // Count and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r     <= status_nxt;
      out_held_count_r <= oks_pkg::OUT_COUNT_W'(count_nxt);
      out_code_read_r  <= code_read_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_held_count = out_held_count_r;
  assign out_code_read  = out_code_read_r;

  // Every accepted transaction yields its result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // The valid cells are exactly as many as the count says.
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("cell valid flags disagree with held count");

  // The count never exceeds the list capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= N)
    else $error("held count exceeds capacity");

  // At most one cell can match a key, since codes are held only once.
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_hit))
    else $error("key held in more than one cell");

  // A full status is only reported when the list really is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status_r == oks_pkg::ST_FULL)) |->
      (int'(count_r) == N))
    else $error("full status with room left in the list");

endmodule

### hdl/oks_cell.sv
// One cell of the ordered key list: holds one code and its valid flag.
// Depends on oks_pkg for the command struct and the code width.
module oks_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  oks_pkg::cell_cmd_t         cmd,
  input  logic                       prev_valid,
  input  logic                       hit_below,
  input  logic [oks_pkg::CODE_W-1:0] nxt_code,
  input  logic                       nxt_valid,
  output logic                       hit,
  output logic                       shift_out,
  output logic [oks_pkg::CODE_W-1:0] code,
  output logic                       valid
);

  logic [oks_pkg::CODE_W-1:0] code_r, code_nxt;
  logic                       valid_r, valid_nxt;
  logic                       is_tail;

  assign hit       = valid_r && (code_r == cmd.key);
  // Once the removed code is found, this cell and every later one take
  // their upper neighbor's contents.
  assign shift_out = hit_below || hit;
  // First empty cell is where an added code lands.
  assign is_tail   = !valid_r && prev_valid;

  always_comb begin
    code_nxt  = code_r;
    valid_nxt = valid_r;
    if (cmd.clr_en) begin
      valid_nxt = 1'b0;
    end else if (cmd.add_en && is_tail) begin
      code_nxt  = cmd.key;
      valid_nxt = 1'b1;
    end else if (cmd.rem_en && shift_out) begin
      code_nxt  = nxt_code;
      valid_nxt = nxt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign code  = code_r;
  assign valid = valid_r;

endmodule
